// ===== rtl/cbc2d_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbc2d_pkg: shared types and constants
// Sizes, command and status structs for the clamped border convolution.
// ---------------------------------------------------------------------------
package cbc2d_pkg;

   localparam int MaxWidth   = 4096;
   localparam int MaxKernel  = 15;
   localparam int KStore     = MaxKernel * MaxKernel;
   localparam int HalfMax    = (MaxKernel - 1) / 2;
   localparam int WidthCap   = (MaxWidth < 4096) ? MaxWidth : 4096;
   localparam int ColW       = $clog2(MaxWidth);
   localparam int RowSlotW   = $clog2(MaxKernel);
   localparam int LineDepth  = MaxKernel * MaxWidth;
   localparam int LineAddrW  = $clog2(LineDepth);
   localparam int KAddrW     = $clog2(KStore);
   localparam int AccW       = 48;

   // row slot by reciprocal multiply; exact for 12-bit rows
   localparam int SlotShift  = 20;
   localparam int SlotMul    = ((1 << SlotShift) + MaxKernel - 1) / MaxKernel;

   localparam logic [1:0] CSR_KERNEL_HALF  = 2'd0;
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic OP_COEF  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic        coef_wr;     // write coefficient from input word
      logic        pix_wr;      // write pixel into line store
      logic        acc_clear;   // start a new output sum
      logic        tap_rd;      // issue one tap read
      logic        out_load;    // round, saturate, load output register
      logic [11:0] ox;          // output column
      logic [11:0] oy;          // output row
      logic        olast;       // last result of this pixel
      logic [11:0] tx;          // clamped tap column
      logic [11:0] ty;          // clamped tap row
      logic [7:0]  kidx;        // kernel index for this tap
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_busy;           // output register holds a stalled word
   } stat_type;

   function automatic logic [11:0] clamp_add(input logic [11:0] base,
                                             input logic [3:0]  off,
                                             input logic [3:0]  half,
                                             input logic [12:0] lim);
      logic signed [14:0] v;
      begin
         v = $signed({3'b000, base}) + $signed({11'd0, off}) - $signed({11'd0, half});
         if (v < 0) clamp_add = '0;
         else if (v > $signed({2'b00, lim}) - 15'sd1) clamp_add = 12'(lim - 13'd1);
         else clamp_add = v[11:0];
      end
   endfunction

   // row mod MaxKernel: quotient from reciprocal, then one subtract
   function automatic logic [RowSlotW-1:0] row_slot(input logic [11:0] r);
      logic [31:0] p;
      logic [11:0] q;
      logic [11:0] rem;
      begin
         p   = 32'(r) * 32'(SlotMul);
         q   = 12'(p >> SlotShift);
         rem = r - 12'(32'(q) * MaxKernel);
         row_slot = RowSlotW'(rem);
      end
   endfunction

endpackage

// ===== rtl/cbc2d_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbc2d_ctrl: sequencer
// Tracks raster position and steps window taps for every freed output.
// ---------------------------------------------------------------------------
module cbc2d_ctrl import cbc2d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  stat_type    stat,
   output cmd_type     cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_TAP  = 5'b00010,
      ST_FIN  = 5'b00100,
      ST_WAIT = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  half_ff, half_in;
   logic [12:0] wid_ff, wid_in, hgt_ff, hgt_in;
   logic [11:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [11:0] x_ff, x_in, y_ff, y_in, xlo_ff, xlo_in, xhi_ff, xhi_in, yhi_ff, yhi_in;
   logic [3:0]  kx_ff, kx_in, ky_ff, ky_in;

   logic [3:0]  h, kmax;
   logic [12:0] w, ht;
   logic [11:0] pcx, pcy, wl, hl;
   logic        accept, fire;

   always_comb begin
      h  = (half_ff > 3'(HalfMax)) ? 4'(HalfMax) : {1'b0, half_ff};
      kmax = {h[2:0], 1'b0};
      w  = (wid_ff == 0) ? 13'd1 : (wid_ff > 13'(WidthCap)) ? 13'(WidthCap) : wid_ff;
      ht = (hgt_ff == 0) ? 13'd1 : (hgt_ff > 13'd4096) ? 13'd4096 : hgt_ff;
      wl = 12'(w - 13'd1);
      hl = 12'(ht - 13'd1);
      pcx = (cx_ff > wl) ? wl : cx_ff;
      pcy = (cy_ff > hl) ? hl : cy_ff;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign fire      = (pcy == hl || pcy >= 12'(h)) && (pcx == wl || pcx >= 12'(h));

   always_comb begin
      state_in = state_ff;
      half_in = half_ff; wid_in = wid_ff; hgt_in = hgt_ff;
      cx_in = cx_ff; cy_in = cy_ff;
      x_in = x_ff; y_in = y_ff; xlo_in = xlo_ff; xhi_in = xhi_ff; yhi_in = yhi_ff;
      kx_in = kx_ff; ky_in = ky_ff;
      cmd = '0;
      cmd.ox = x_ff; cmd.oy = y_ff;
      cmd.olast = (x_ff == xhi_ff) && (y_ff == yhi_ff);
      cmd.tx = clamp_add(x_ff, kx_ff, h, w);
      cmd.ty = clamp_add(y_ff, ky_ff, h, ht);
      cmd.kidx = 8'(ky_ff) * 8'(kmax + 4'd1) + 8'(kx_ff);
      if (csr_write) begin
         // known registers restart the frame
         case (csr_index)
            CSR_KERNEL_HALF: begin
               half_in = csr_data[2:0];
               cx_in = '0; cy_in = '0;
            end
            CSR_FRAME_WIDTH: begin
               wid_in = csr_data;
               cx_in = '0; cy_in = '0;
            end
            CSR_FRAME_HEIGHT: begin
               hgt_in = csr_data;
               cx_in = '0; cy_in = '0;
            end
            default: ;
         endcase
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_COEF) begin
                  cmd.coef_wr = 1'b1;
               end else begin
                  cmd.pix_wr = 1'b1;
                  cmd.tx = pcx; cmd.ty = pcy;
                  if (pcy == hl) begin
                     y_in = (hl > 12'(h)) ? hl - 12'(h) : '0;
                     yhi_in = hl;
                  end else begin
                     y_in = pcy - 12'(h); yhi_in = pcy - 12'(h);
                  end
                  if (pcx == wl) begin
                     x_in = (wl > 12'(h)) ? wl - 12'(h) : '0;
                     xlo_in = x_in; xhi_in = wl;
                  end else begin
                     x_in = pcx - 12'(h); xlo_in = x_in; xhi_in = x_in;
                  end
                  kx_in = '0; ky_in = '0;
                  if (fire) state_in = ST_TAP;
                  if (pcx + 12'd1 >= wl + 12'd1 && pcx == wl) begin
                     cx_in = '0;
                     cy_in = (pcy == hl) ? '0 : pcy + 12'd1;
                  end else begin
                     cx_in = pcx + 12'd1; cy_in = pcy;
                  end
               end
            end
         end
         ST_TAP: begin
            cmd.tap_rd = 1'b1;
            cmd.acc_clear = (kx_ff == 0) && (ky_ff == 0);
            if (kx_ff == kmax) begin
               kx_in = '0;
               if (ky_ff == kmax) state_in = ST_FIN;
               else ky_in = ky_ff + 4'd1;
            end else begin
               kx_in = kx_ff + 4'd1;
            end
         end
         ST_FIN:  state_in = ST_WAIT;  // last tap in read stage
         ST_WAIT: state_in = ST_OUT;   // last product into accumulator
         ST_OUT: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               kx_in = '0; ky_in = '0;
               if (cmd.olast) state_in = ST_IDLE;
               else begin
                  state_in = ST_TAP;
                  if (x_ff == xhi_ff) begin
                     x_in = xlo_ff; y_in = y_ff + 12'd1;
                  end else x_in = x_ff + 12'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         half_ff <= 3'd1; wid_ff <= 13'd512; hgt_ff <= 13'd512;
         cx_ff <= '0; cy_ff <= '0;
      end else begin
         state_ff <= state_in;
         half_ff <= half_in; wid_ff <= wid_in; hgt_ff <= hgt_in;
         cx_ff <= cx_in; cy_ff <= cy_in;
      end
      x_ff <= x_in; y_ff <= y_in; xlo_ff <= xlo_in; xhi_ff <= xhi_in; yhi_ff <= yhi_in;
      kx_ff <= kx_in; ky_ff <= ky_in;
   end

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("accept while busy");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAP) |-> (kx_ff <= kmax && ky_ff <= kmax))
      else $error("tap index out of window");

endmodule

// ===== rtl/cbc2d_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbc2d_datapath: stores, multiplier, accumulator, output register
// One tap per cycle: memory read, multiply, accumulate.
// ---------------------------------------------------------------------------
module cbc2d_datapath import cbc2d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [7:0]         req_coef_index,
   input  logic signed [17:0] req_coef_value,
   input  logic [15:0]        req_pixel_value,
   output stat_type           stat,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [11:0]        rsp_out_x,
   output logic [11:0]        rsp_out_y,
   output logic signed [23:0] rsp_out_value,
   output logic               rsp_last_of_run
);

   logic signed [17:0] coef_mem [KStore];
   logic [15:0]        line_mem [LineDepth];

   logic [LineAddrW-1:0] laddr;
   logic [15:0]          pix_ff;
   logic signed [17:0]   cf_ff;
   logic                 rd_ff, clr_ff, mv_ff, mclr_ff;
   logic signed [34:0]   prod_ff;
   logic signed [AccW-1:0] acc_ff;
   logic signed [AccW-1:0] rnd;
   logic signed [23:0]   sat;
   logic                 valid_ff;

   assign laddr = LineAddrW'(32'(row_slot(cmd.ty)) * MaxWidth) + LineAddrW'(cmd.tx);

   always_ff @(posedge clock) begin
      if (cmd.coef_wr && req_coef_index < 8'(KStore))
         coef_mem[KAddrW'(req_coef_index)] <= req_coef_value;
      if (cmd.pix_wr)
         line_mem[laddr] <= req_pixel_value;
      pix_ff <= line_mem[laddr];
      cf_ff  <= coef_mem[KAddrW'(cmd.kidx)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0; mv_ff <= 1'b0;
      end else begin
         rd_ff <= cmd.tap_rd; mv_ff <= rd_ff;
      end
      clr_ff  <= cmd.acc_clear;
      mclr_ff <= clr_ff;
      prod_ff <= $signed({1'b0, pix_ff}) * cf_ff;
      if (mv_ff) acc_ff <= (mclr_ff ? '0 : acc_ff) + AccW'(prod_ff);
   end

   always_comb begin
      rnd = (acc_ff + AccW'(32768)) >>> 16;
      if (rnd > AccW'(8388607)) sat = 24'sh7FFFFF;
      else if (rnd < -AccW'(8388608)) sat = -24'sh800000;
      else sat = rnd[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.out_load) valid_ff <= 1'b1;
      else if (!rsp_stall) valid_ff <= 1'b0;
      if (cmd.out_load) begin
         rsp_out_x <= cmd.ox; rsp_out_y <= cmd.oy;
         rsp_out_value <= sat; rsp_last_of_run <= cmd.olast;
      end
   end

   assign rsp_valid = valid_ff;
   assign stat.out_busy = valid_ff && rsp_stall;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(valid_ff && rsp_stall)) else $error("output overwritten");
   a_pipe: assert property (@(posedge clock) disable iff (reset)
      rd_ff |=> mv_ff) else $error("tap pipeline lost");
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rd_ff && !mv_ff) else $error("load before sum done");

endmodule

// ===== rtl/clamped_border_conv2d_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clamped_border_conv2d_top: 2D convolution with replicated borders
// Streams raster pixels and emits filtered pixels as their windows complete.
// ---------------------------------------------------------------------------
// A coefficient word, and a pixel word that frees no output, leave the
// input unstalled. A pixel that frees outputs holds the input while each
// freed output reads every tap of its window through the single
// multiply-accumulate unit, one tap per cycle from the line store port,
// and while the result side stalls.
// Results leave through a registered word;
// the input stays stalled until every result of the pixel is loaded.
// Configuration writes restart the frame position; stores keep contents.
module clamped_border_conv2d_top import cbc2d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [12:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [7:0]         req_coef_index,
   input  logic signed [17:0] req_coef_value,
   input  logic [15:0]        req_pixel_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [11:0]        rsp_out_x,
   output logic [11:0]        rsp_out_y,
   output logic signed [23:0] rsp_out_value,
   output logic               rsp_last_of_run
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: raster counters, window stepping, handshakes
   cbc2d_ctrl u_ctrl (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_valid, .req_stall, .req_operation, .stat, .cmd
   );

   // stores and arithmetic
   cbc2d_datapath u_dp (
      .clock, .reset, .cmd, .req_coef_index, .req_coef_value, .req_pixel_value,
      .stat, .rsp_stall, .rsp_valid, .rsp_out_x, .rsp_out_y, .rsp_out_value,
      .rsp_last_of_run
   );

endmodule
